// ===== rtl/clamp_trimmed_mean_filter_defines.svh =====
// Assertion macros shared by the clamp trimmed mean filter RTL.
`ifndef CLAMP_TRIMMED_MEAN_FILTER_DEFINES_SVH
`define CLAMP_TRIMMED_MEAN_FILTER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CTMF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define CTMF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ctmf_pkg.sv =====
// Types, constants and control structs of the clamp trimmed mean filter.
`default_nettype none

package ctmf_pkg;

	localparam int CHANNELS       = 4;
	localparam int SAMPLE_BITS    = 12;
	localparam int WINDOW_LEN_DEF = 8;
	localparam int THR_BITS       = 12;
	localparam int APB_DATA_BITS  = 32;
	localparam int APB_ADDR_BITS  = 3;

	localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(200);

	// register index taken from paddr[2]
	localparam logic REG_JUMP_THRESHOLD = 1'b0;

	typedef logic [SAMPLE_BITS-1:0] sample_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_TRIM,
		ST_MUL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clear;
		logic acc;
		logic trim;
		logic mul;
		logic commit;
	} lane_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/ctmf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module ctmf_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/ctmf_lane.sv =====
// One channel lane: jump clamp, window min/max/sum scan, trimmed mean by reciprocal.
`default_nettype none

module ctmf_lane
	import ctmf_pkg::*;
#(
	parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire lane_ctrl_t          ctrl,
	input  wire logic [THR_BITS-1:0] thr,
	input  wire sample_t             sample,
	input  wire sample_t             rd_data,
	output      sample_t             kept,
	output      logic                clamped,
	output      sample_t             mean
);

	localparam int SUM_BITS  = SAMPLE_BITS + $clog2(WINDOW_LEN);
	localparam int DIVISOR   = WINDOW_LEN - 2;
	localparam int SHIFT     = SUM_BITS + $clog2(DIVISOR);
	localparam int PROD_BITS = 2 * SUM_BITS + 1;
	localparam longint unsigned RECIP_FULL =
		((64'd1 << SHIFT) + longint'(DIVISOR) - 64'd1) / longint'(DIVISOR);
	localparam logic [63:0] RECIP_VEC = RECIP_FULL;
	localparam logic [SUM_BITS:0] RECIP = RECIP_VEC[SUM_BITS:0];

	sample_t                 prev_q;
	sample_t                 diff;
	logic [SUM_BITS-1:0]     sum_q;
	sample_t                 lo_q;
	sample_t                 hi_q;
	logic [SUM_BITS-1:0]     trimmed_q;
	logic [PROD_BITS-1:0]    product_q;
	logic [PROD_BITS-1:0]    quotient;

	assign diff    = (sample > prev_q) ? (sample - prev_q) : (prev_q - sample);
	assign clamped = diff > thr;
	assign kept    = clamped ? prev_q : sample;

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			sum_q <= '0;
			lo_q  <= '1;
			hi_q  <= '0;
		end else if (ctrl.acc) begin
			sum_q <= sum_q + SUM_BITS'(rd_data);
			if (rd_data < lo_q) begin
				lo_q <= rd_data;
			end
			if (rd_data > hi_q) begin
				hi_q <= rd_data;
			end
		end
		if (ctrl.trim) begin
			trimmed_q <= sum_q - SUM_BITS'(lo_q) - SUM_BITS'(hi_q);
		end
		if (ctrl.mul) begin
			product_q <= PROD_BITS'(trimmed_q) * PROD_BITS'(RECIP);
		end
	end

	assign quotient = product_q >> SHIFT;
	assign mean     = quotient[SAMPLE_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (ctrl.commit) begin
			prev_q <= mean;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/clamp_trimmed_mean_filter.sv =====
// Clamp trimmed mean filter top level: control, window memory, lanes, ports.
`default_nettype none
`include "clamp_trimmed_mean_filter_defines.svh"

// Each input beat carries one frame of four 12-bit samples. Per channel, a sample that
// differs from the channel's previous output by more than jump_threshold is replaced by
// that previous output; the kept value goes into the channel's circular window at a
// shared write position, and the result is floor((sum - min - max) / (WINDOW_LEN - 2))
// over the window, with clamped_mask flagging replaced samples. The windows of all
// channels share one memory row per position, and each item scans that memory one row
// per cycle; the next item is accepted only after the scan, trim, multiply and commit of
// the current one, and in_stall is high throughout. The result waits in an output
// register, so a stalled output holds only the finishing item.
// Window rows carry valid bits cleared at reset and read as zero until written, so the
// block accepts items directly after reset with no clearing pass.
module clamp_trimmed_mean_filter
	import ctmf_pkg::*;
#(
	parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [APB_ADDR_BITS-1:0] paddr,
	input  wire logic [APB_DATA_BITS-1:0] pwdata,
	output      logic [APB_DATA_BITS-1:0] prdata,
	output      logic                     pready,
	input  wire logic                     in_valid,
	output      logic                     in_stall,
	input  wire sample_t                  sample_ch0,
	input  wire sample_t                  sample_ch1,
	input  wire sample_t                  sample_ch2,
	input  wire sample_t                  sample_ch3,
	output      logic                     out_valid,
	input  wire logic                     out_stall,
	output      sample_t                  filtered_ch0,
	output      sample_t                  filtered_ch1,
	output      sample_t                  filtered_ch2,
	output      sample_t                  filtered_ch3,
	output      logic [CHANNELS-1:0]      clamped_mask
);

	localparam int ADDR_BITS = $clog2(WINDOW_LEN);
	localparam int ROW_BITS  = CHANNELS * SAMPLE_BITS;
	localparam logic [ADDR_BITS-1:0] LAST_POS = ADDR_BITS'(WINDOW_LEN - 1);

	state_t                   state_q;
	state_t                   state_d;
	lane_ctrl_t               lane_ctrl;
	logic [THR_BITS-1:0]      thr_q;
	logic [ADDR_BITS-1:0]     wr_pos_q;
	logic [ADDR_BITS-1:0]     rd_cnt_q;
	logic [WINDOW_LEN-1:0]    row_valid_q;
	logic                     rd_pend_s1;
	logic                     rd_ok_s1;
	logic                     accept;
	logic                     re;
	logic                     out_free;
	logic                     cfg_wr;
	logic [ROW_BITS-1:0]      wr_row;
	logic [ROW_BITS-1:0]      rd_row;
	logic [CHANNELS-1:0]      clamped;
	logic [CHANNELS-1:0]      mask_q;
	logic                     out_valid_q;
	sample_t                  samples  [CHANNELS];
	sample_t                  kept     [CHANNELS];
	sample_t                  means    [CHANNELS];
	sample_t                  rd_lane  [CHANNELS];
	sample_t                  out_q    [CHANNELS];

	assign samples[0] = sample_ch0;
	assign samples[1] = sample_ch1;
	assign samples[2] = sample_ch2;
	assign samples[3] = sample_ch3;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_JUMP_THRESHOLD);
	assign prdata = (paddr[2] == REG_JUMP_THRESHOLD) ?
		{{(APB_DATA_BITS - THR_BITS){1'b0}}, thr_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_wr) begin
			thr_q <= pwdata[THR_BITS-1:0];
		end
	end

	// sequencer
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		in_stall         = 1'b1;
		re               = 1'b0;
		lane_ctrl.clear  = 1'b0;
		lane_ctrl.acc    = rd_pend_s1;
		lane_ctrl.trim   = 1'b0;
		lane_ctrl.mul    = 1'b0;
		lane_ctrl.commit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall        = 1'b0;
				lane_ctrl.clear = in_valid;
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				re = 1'b1;
				if (rd_cnt_q == LAST_POS) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_TRIM;
			end
			ST_TRIM: begin
				lane_ctrl.trim = 1'b1;
				state_d        = ST_MUL;
			end
			ST_MUL: begin
				lane_ctrl.mul = 1'b1;
				state_d       = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					lane_ctrl.commit = 1'b1;
					state_d          = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pos_q    <= '0;
			rd_cnt_q    <= '0;
			row_valid_q <= '0;
			rd_pend_s1  <= 1'b0;
			rd_ok_s1    <= 1'b0;
			mask_q      <= '0;
		end else begin
			rd_pend_s1 <= re;
			if (accept) begin
				rd_cnt_q              <= '0;
				row_valid_q[wr_pos_q] <= 1'b1;
				mask_q                <= clamped;
			end else if (re) begin
				rd_cnt_q <= rd_cnt_q + ADDR_BITS'(1);
			end
			if (re) begin
				rd_ok_s1 <= row_valid_q[rd_cnt_q];
			end
			if (lane_ctrl.commit) begin
				wr_pos_q <= (wr_pos_q == LAST_POS) ? '0 : wr_pos_q + ADDR_BITS'(1);
			end
		end
	end

	// window memory, one row per position holding all channels
	ctmf_ram #(
		.WIDTH(ROW_BITS),
		.DEPTH(WINDOW_LEN)
	) u_window (
		.clk   (clk),
		.we    (accept),
		.waddr (wr_pos_q),
		.wdata (wr_row),
		.re    (re),
		.raddr (rd_cnt_q),
		.rdata (rd_row)
	);

	for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
		assign wr_row[c*SAMPLE_BITS +: SAMPLE_BITS] = kept[c];
		assign rd_lane[c] = rd_ok_s1 ? rd_row[c*SAMPLE_BITS +: SAMPLE_BITS] : '0;

		ctmf_lane #(
			.WINDOW_LEN(WINDOW_LEN)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (lane_ctrl),
			.thr     (thr_q),
			.sample  (samples[c]),
			.rd_data (rd_lane[c]),
			.kept    (kept[c]),
			.clamped (clamped[c]),
			.mean    (means[c])
		);

		always_ff @(posedge clk) begin
			if (lane_ctrl.commit) begin
				out_q[c] <= means[c];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (lane_ctrl.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	logic [CHANNELS-1:0] out_mask_q;

	always_ff @(posedge clk) begin
		if (lane_ctrl.commit) begin
			out_mask_q <= mask_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign filtered_ch0 = out_q[0];
	assign filtered_ch1 = out_q[1];
	assign filtered_ch2 = out_q[2];
	assign filtered_ch3 = out_q[3];
	assign clamped_mask = out_mask_q;

	`CTMF_ASSERT_NEXT(a_accept_starts_scan, accept, state_q == ST_SCAN,
		"accepted beat did not start the window scan")
	`CTMF_ASSERT_SAME(a_read_in_scan, rd_pend_s1,
		state_q == ST_SCAN || state_q == ST_DRAIN,
		"window read data returned outside the scan")
	`CTMF_ASSERT_NEXT(a_hold_result, state_q == ST_DONE && out_valid_q && out_stall,
		state_q == ST_DONE && out_valid_q,
		"result overwrote a stalled output beat")
	`CTMF_ASSERT_NEXT(a_advance_pos, lane_ctrl.commit, wr_pos_q != $past(wr_pos_q),
		"write position did not advance after a result")

endmodule

`default_nettype wire

// ===== sim/tb_clamp_trimmed_mean_filter.sv =====
// Testbench for the clamp trimmed mean filter: predicts every frame's result and checks it.
`timescale 1ns / 100ps

import ctmf_pkg::*;

localparam int TB_WIN = WINDOW_LEN_DEF;

typedef struct packed {
	logic [CHANNELS-1:0][SAMPLE_BITS-1:0] filt;
	logic [CHANNELS-1:0]                  mask;
} frame_result_t;

class filter_scoreboard;
	sample_t             window_mem [CHANNELS][TB_WIN];
	sample_t             last_out [CHANNELS];
	int unsigned         wpos;
	logic [THR_BITS-1:0] thr;
	frame_result_t       pending_results [$];
	int                  mismatches;

	function new();
		foreach (window_mem[c, k]) window_mem[c][k] = '0;
		foreach (last_out[c]) last_out[c] = '0;
		wpos = 0;
		thr = THR_RESET;
		mismatches = 0;
	endfunction

	function void write_reg(int idx, logic [APB_DATA_BITS-1:0] val);
		if (idx == int'(REG_JUMP_THRESHOLD)) thr = val[THR_BITS-1:0];
	endfunction

	function void note_frame(sample_t s [CHANNELS]);
		frame_result_t r;
		int unsigned   diff;
		int unsigned   sum;
		int unsigned   lo;
		int unsigned   hi;
		sample_t       kept;
		r = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			diff = (s[c] > last_out[c]) ? s[c] - last_out[c] : last_out[c] - s[c];
			kept = s[c];
			if (diff > thr) begin
				kept = last_out[c];
				r.mask[c] = 1'b1;
			end
			window_mem[c][wpos] = kept;
			sum = 0;
			lo = window_mem[c][0];
			hi = window_mem[c][0];
			for (int k = 0; k < TB_WIN; k++) begin
				sum += window_mem[c][k];
				if (window_mem[c][k] < lo) lo = window_mem[c][k];
				if (window_mem[c][k] > hi) hi = window_mem[c][k];
			end
			last_out[c] = sample_t'((sum - lo - hi) / (TB_WIN - 2));
			r.filt[c] = last_out[c];
		end
		wpos = (wpos + 1) % TB_WIN;
		pending_results.push_back(r);
	endfunction

	function void flag(string what, int want, int got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected %0d, got %0d", what, want, got);
	endfunction

	function void check_result(frame_result_t got);
		frame_result_t want;
		if (pending_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result with no frame pending: filt %h mask %h", got.filt, got.mask);
			return;
		end
		want = pending_results.pop_front();
		for (int c = 0; c < CHANNELS; c++)
			if (got.filt[c] !== want.filt[c])
				flag($sformatf("filtered_ch%0d", c), want.filt[c], got.filt[c]);
		if (got.mask !== want.mask) flag("clamped_mask", want.mask, got.mask);
	endfunction

	function int pending();
		return pending_results.size();
	endfunction
endclass

module tb_clamp_trimmed_mean_filter;
	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 260;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [APB_ADDR_BITS-1:0] paddr = '0;
	logic [APB_DATA_BITS-1:0] pwdata = '0;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	sample_t                  sample_ch0 = '0;
	sample_t                  sample_ch1 = '0;
	sample_t                  sample_ch2 = '0;
	sample_t                  sample_ch3 = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	sample_t                  filtered_ch0;
	sample_t                  filtered_ch1;
	sample_t                  filtered_ch2;
	sample_t                  filtered_ch3;
	logic [CHANNELS-1:0]      clamped_mask;

	filter_scoreboard sb;
	frame_result_t    got;
	int               tx_idle_pct = 0;
	int               rx_idle_pct = 0;
	bit               hold_rx = 1'b0;
	int               quiet_cycles = 0;

	always #1 clk = ~clk;

	clamp_trimmed_mean_filter dut (.*);

	initial begin
		forever begin
			@(posedge clk);
			if (hold_rx) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rx = 1'b0;
			end
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got.filt[0] = filtered_ch0;
				got.filt[1] = filtered_ch1;
				got.filt[2] = filtered_ch2;
				got.filt[3] = filtered_ch3;
				got.mask = clamped_mask;
				sb.check_result(got);
			end
			if ((out_valid && !out_stall) || (in_valid && !in_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL clamp_trimmed_mean_filter");
				$finish;
			end
		end
	end

	task automatic apb_write(input int idx, input logic [APB_DATA_BITS-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_ADDR_BITS'(idx * 4);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.write_reg(idx, val);
	endtask

	task automatic send_frame(input sample_t s [CHANNELS]);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample_ch0 <= s[0];
		sample_ch1 <= s[1];
		sample_ch2 <= s[2];
		sample_ch3 <= s[3];
		do @(posedge clk); while (in_stall);
		sb.note_frame(s);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic sample_t offset_sample(int c, int delta);
		int v;
		v = int'(sb.last_out[c]) + delta;
		if (v < 0) v = 0;
		if (v > 4095) v = 4095;
		return sample_t'(v);
	endfunction

	function automatic void edge_frame(output sample_t s [CHANNELS]);
		int t;
		t = int'(sb.thr);
		s[0] = offset_sample(0, t);
		s[1] = offset_sample(1, t + 1);
		s[2] = offset_sample(2, -t);
		s[3] = offset_sample(3, -t - 1);
	endfunction

	function automatic sample_t random_sample(int c);
		int r;
		int t;
		int sgn;
		r = $urandom_range(99);
		t = int'(sb.thr);
		sgn = $urandom_range(1) ? 1 : -1;
		if (r < 60) return offset_sample(c, sgn * int'($urandom_range(t)));
		if (r < 75) return offset_sample(c, sgn * (t + int'($urandom_range(1))));
		if (r < 92) return sample_t'($urandom_range(4095));
		return $urandom_range(1) ? '1 : '0;
	endfunction

	task automatic directed_part();
		sample_t s [CHANNELS];
		// index past the register list: no effect
		apb_write(1, '0);
		s = '{default: 0};
		send_frame(s);
		s = '{default: 200};
		send_frame(s);
		s = '{default: 4095};
		send_frame(s);
		repeat (2) begin
			edge_frame(s);
			send_frame(s);
		end
		drain();
		apb_write(int'(REG_JUMP_THRESHOLD), 4095);
		s = '{default: 4095};
		repeat (3) send_frame(s);
		s = '{0, 4095, 0, 4095};
		send_frame(s);
		s = '{4095, 0, 4095, 0};
		send_frame(s);
		edge_frame(s);
		send_frame(s);
		drain();
		apb_write(int'(REG_JUMP_THRESHOLD), 0);
		foreach (s[c]) s[c] = sb.last_out[c];
		send_frame(s);
		s = '{offset_sample(0, 1), offset_sample(1, -1), 0, 4095};
		send_frame(s);
		edge_frame(s);
		send_frame(s);
		drain();
	endtask

	task automatic random_phase(input int thr_val, input int tx, input int rx, input bit squeeze);
		sample_t s [CHANNELS];
		apb_write(int'(REG_JUMP_THRESHOLD), thr_val);
		tx_idle_pct = tx;
		rx_idle_pct = rx;
		if (squeeze) hold_rx = 1'b1;
		repeat (PHASE_ITEMS) begin
			foreach (s[c]) s[c] = random_sample(c);
			send_frame(s);
		end
		drain();
	endtask

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_part();
		random_phase(int'(THR_RESET), 28, 51, 1'b1);
		random_phase(int'($urandom_range(4095)), 51, 28, 1'b0);
		random_phase(4095, 0, 0, 1'b0);
		random_phase(0, 0, 0, 1'b0);
		random_phase(int'($urandom_range(1, 64)), 0, 0, 1'b0);
		repeat (30) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("PASS clamp_trimmed_mean_filter");
		else
			$display("FAIL clamp_trimmed_mean_filter");
		$finish;
	end
endmodule
